[rtl/stt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and tables of the source text tokenizer
// Scan states, token kinds, character classes, operator and delimiter codes
// and the keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int LINE_BITS  = 16;
   localparam int COL_BITS   = 16;
   localparam int LEN_BITS   = 16;
   localparam int MAX_RES    = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = PTR_BITS + 1;
   localparam int NUM_KW     = 7;
   localparam int KW_MAX     = 6;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_INT,
      SCAN_DOT,
      SCAN_FRAC,
      SCAN_IDENT,
      SCAN_OP
   } scan_type;

   typedef enum logic [2:0] {
      KIND_NUMBER,
      KIND_DELIM,
      KIND_OP,
      KIND_KEYWORD,
      KIND_IDENT,
      KIND_UNKNOWN
   } kind_type;

   // byte codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   // operator codes
   localparam logic [7:0] OP_EQ_EQ    = 8'd0;
   localparam logic [7:0] OP_NE       = 8'd1;
   localparam logic [7:0] OP_LE       = 8'd2;
   localparam logic [7:0] OP_GE       = 8'd3;
   localparam logic [7:0] OP_POW      = 8'd4;
   localparam logic [7:0] OP_FLOORDIV = 8'd5;
   localparam logic [7:0] OP_ADD_EQ   = 8'd6;
   localparam logic [7:0] OP_SUB_EQ   = 8'd7;
   localparam logic [7:0] OP_MUL_EQ   = 8'd8;
   localparam logic [7:0] OP_DIV_EQ   = 8'd9;
   localparam logic [7:0] OP_ADD      = 8'd10;
   localparam logic [7:0] OP_SUB      = 8'd11;
   localparam logic [7:0] OP_MUL      = 8'd12;
   localparam logic [7:0] OP_DIV      = 8'd13;
   localparam logic [7:0] OP_MOD      = 8'd14;
   localparam logic [7:0] OP_ASSIGN   = 8'd15;
   localparam logic [7:0] OP_LT       = 8'd16;
   localparam logic [7:0] OP_GT       = 8'd17;

   // delimiter codes
   localparam logic [7:0] DL_LBRACE = 8'd0;
   localparam logic [7:0] DL_RBRACE = 8'd1;
   localparam logic [7:0] DL_LPAREN = 8'd2;
   localparam logic [7:0] DL_RPAREN = 8'd3;
   localparam logic [7:0] DL_LBRACK = 8'd4;
   localparam logic [7:0] DL_RBRACK = 8'd5;
   localparam logic [7:0] DL_COLON  = 8'd6;
   localparam logic [7:0] DL_DQUOTE = 8'd7;
   localparam logic [7:0] DL_SQUOTE = 8'd8;

   localparam logic [7:0] DETAIL_NONE = 8'd0;
   localparam logic [7:0] DETAIL_FRAC = 8'd1;

   // if elif else for while def return
   localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:KW_MAX-1] = '{
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "i", "f", 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"d", "e", "f", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n"}
   };
   localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd5, 3'd3, 3'd6
   };

   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } match_type;

   typedef struct packed {
      kind_type        kind;
      logic [7:0]      detail;
      logic [15:0]     line;
      logic [15:0]     column;
      logic [15:0]     length;
      logic            last;
   } token_type;

   typedef struct packed {
      scan_type                scan;
      logic [7:0]              pending_op;
      logic [NUM_KW-1:0]       kw_live;
      logic [LINE_BITS-1:0]    line;
      logic [COL_BITS-1:0]     col;
      logic [COL_BITS-1:0]     tok_start;
      logic [LEN_BITS-1:0]     tok_len;
   } state_type;

   localparam state_type STATE_RESET = '{
      scan:       SCAN_IDLE,
      pending_op: 8'h00,
      kw_live:    '0,
      line:       LINE_BITS'(1),
      col:        '0,
      tok_start:  '0,
      tok_len:    '0
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
             (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic match_type delim_match(input logic [7:0] c);
      match_type m;
      m.hit = 1'b1;
      unique case (c)
         "{":     m.code = DL_LBRACE;
         "}":     m.code = DL_RBRACE;
         "(":     m.code = DL_LPAREN;
         ")":     m.code = DL_RPAREN;
         "[":     m.code = DL_LBRACK;
         "]":     m.code = DL_RBRACK;
         ":":     m.code = DL_COLON;
         8'h22:   m.code = DL_DQUOTE;
         8'h27:   m.code = DL_SQUOTE;
         default: begin
            m.hit  = 1'b0;
            m.code = 8'h00;
         end
      endcase
      return m;
   endfunction

   function automatic logic [7:0] single_op(input logic [7:0] c);
      logic [7:0] code;
      unique case (c)
         CH_PLUS:  code = OP_ADD;
         CH_MINUS: code = OP_SUB;
         CH_STAR:  code = OP_MUL;
         CH_SLASH: code = OP_DIV;
         CH_EQ:    code = OP_ASSIGN;
         CH_LT:    code = OP_LT;
         default:  code = OP_GT;
      endcase
      return code;
   endfunction

   function automatic match_type pair_op(input logic [7:0] p, input logic [7:0] c);
      match_type m;
      m.hit  = 1'b0;
      m.code = 8'h00;
      if (c == CH_EQ) begin
         m.hit = 1'b1;
         unique case (p)
            CH_EQ:    m.code = OP_EQ_EQ;
            CH_BANG:  m.code = OP_NE;
            CH_LT:    m.code = OP_LE;
            CH_GT:    m.code = OP_GE;
            CH_PLUS:  m.code = OP_ADD_EQ;
            CH_MINUS: m.code = OP_SUB_EQ;
            CH_STAR:  m.code = OP_MUL_EQ;
            CH_SLASH: m.code = OP_DIV_EQ;
            default:  m.hit  = 1'b0;
         endcase
      end else if ((c == CH_STAR) && (p == CH_STAR)) begin
         m.hit  = 1'b1;
         m.code = OP_POW;
      end else if ((c == CH_SLASH) && (p == CH_SLASH)) begin
         m.hit  = 1'b1;
         m.code = OP_FLOORDIV;
      end
      return m;
   endfunction

   function automatic logic [15:0] clip16(input logic [31:0] v);
      return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

`default_nettype wire

[rtl/stt_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stt_step: scan step for one source byte
// From the held scan state and one input beat, forms the next scan state and
// the up to three tokens that the byte completes.
// ----------------------------------------------------------------------------
module stt_step
   import stt_pkg::*;
(
   input  state_type                   cur,
   input  logic [7:0]                  ch,
   input  logic                        end_of_text,
   output state_type                   nxt,
   output token_type [MAX_RES-1:0]     res,
   output logic [1:0]                  res_count
);

   function automatic token_type tok(input kind_type kind, input logic [7:0] detail,
                                     input logic [LINE_BITS-1:0] line,
                                     input logic [COL_BITS-1:0] col,
                                     input logic [LEN_BITS-1:0] len);
      token_type t;
      t.kind   = kind;
      t.detail = detail;
      t.line   = clip16(32'(line));
      t.column = clip16(32'(col));
      t.length = clip16(32'(len));
      t.last   = 1'b0;
      return t;
   endfunction

   logic [COL_BITS-1:0]  col_inc;
   logic [LEN_BITS-1:0]  len_inc;
   logic [LEN_BITS-1:0]  len_inc2;
   logic [LINE_BITS-1:0] line_inc;
   logic                 done;
   match_type            pair;
   match_type            delim;
   token_type            pr;
   logic                 pr_v;
   token_type            fl0;
   token_type            fl1;
   logic [1:0]           fl_n;
   token_type            fr;
   logic                 fr_v;
   logic                 kw_found;
   logic [7:0]           kw_code;
   logic [NUM_KW-1:0]    kw_first;
   state_type            step_st;
   state_type            fresh_st;
   token_type [MAX_RES-1:0] raw;

   assign col_inc  = (cur.col == '1) ? cur.col : cur.col + 1'b1;
   assign len_inc  = (cur.tok_len == '1) ? cur.tok_len : cur.tok_len + 1'b1;
   assign len_inc2 = (cur.tok_len >= {{(LEN_BITS-1){1'b1}}, 1'b0}) ? '1
                                                                   : cur.tok_len + 2'd2;
   assign line_inc = (cur.line == '1) ? cur.line : cur.line + 1'b1;
   assign pair     = pair_op(cur.pending_op, ch);
   assign delim    = delim_match(ch);

   // continue the held token
   always_comb begin
      step_st = cur;
      done    = 1'b0;
      pr      = tok(KIND_OP, pair.code, cur.line, cur.tok_start, LEN_BITS'(2));
      pr_v    = 1'b0;
      unique case (cur.scan)
         SCAN_INT: begin
            if (is_digit(ch)) begin
               step_st.tok_len = len_inc;
               step_st.col     = col_inc;
               done            = 1'b1;
            end else if (ch == CH_DOT) begin
               step_st.scan = SCAN_DOT;
               step_st.col  = col_inc;
               done         = 1'b1;
            end
         end
         SCAN_DOT: begin
            if (is_digit(ch)) begin
               step_st.tok_len = len_inc2;
               step_st.scan    = SCAN_FRAC;
               step_st.col     = col_inc;
               done            = 1'b1;
            end
         end
         SCAN_FRAC: begin
            if (is_digit(ch)) begin
               step_st.tok_len = len_inc;
               step_st.col     = col_inc;
               done            = 1'b1;
            end
         end
         SCAN_IDENT: begin
            if (is_alpha(ch) || is_digit(ch)) begin
               for (int k = 0; k < NUM_KW; k++) begin
                  step_st.kw_live[k] = cur.kw_live[k] &&
                                       (cur.tok_len < LEN_BITS'(KW_LEN[k])) &&
                                       (KW_TEXT[k][cur.tok_len[2:0]] == ch);
               end
               step_st.tok_len = len_inc;
               step_st.col     = col_inc;
               done            = 1'b1;
            end
         end
         SCAN_OP: begin
            if (pair.hit) begin
               pr_v               = 1'b1;
               step_st.scan       = SCAN_IDLE;
               step_st.pending_op = 8'h00;
               step_st.tok_len    = '0;
               step_st.col        = col_inc;
               done               = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // flush the held token
   always_comb begin
      kw_found = 1'b0;
      kw_code  = 8'h00;
      for (int k = 0; k < NUM_KW; k++) begin
         if (!kw_found && cur.kw_live[k] && (cur.tok_len == LEN_BITS'(KW_LEN[k]))) begin
            kw_found = 1'b1;
            kw_code  = 8'(k);
         end
      end
      fl0  = tok(KIND_NUMBER, DETAIL_NONE, cur.line, cur.tok_start, cur.tok_len);
      fl1  = tok(KIND_UNKNOWN, CH_DOT, cur.line, cur.col, LEN_BITS'(1));
      fl_n = 2'd0;
      unique case (cur.scan)
         SCAN_INT:  fl_n = 2'd1;
         SCAN_DOT:  fl_n = 2'd2;
         SCAN_FRAC: begin
            fl0.detail = DETAIL_FRAC;
            fl_n       = 2'd1;
         end
         SCAN_IDENT: begin
            fl0.kind   = kw_found ? KIND_KEYWORD : KIND_IDENT;
            fl0.detail = kw_code;
            fl_n       = 2'd1;
         end
         SCAN_OP: begin
            fl0.length = 16'd1;
            if (cur.pending_op == CH_BANG) begin
               fl0.kind   = KIND_UNKNOWN;
               fl0.detail = CH_BANG;
            end else begin
               fl0.kind   = KIND_OP;
               fl0.detail = single_op(cur.pending_op);
            end
            fl_n = 2'd1;
         end
         default: ;
      endcase
   end

   // start afresh from idle
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         kw_first[k] = (KW_TEXT[k][0] == ch);
      end
      fresh_st            = cur;
      fresh_st.scan       = SCAN_IDLE;
      fresh_st.pending_op = 8'h00;
      fresh_st.kw_live    = '0;
      fresh_st.tok_len    = '0;
      fr   = tok(KIND_UNKNOWN, ch, cur.line, col_inc, LEN_BITS'(1));
      fr_v = 1'b0;
      if (ch == CH_LF) begin
         fresh_st.line = line_inc;
         fresh_st.col  = '0;
      end else begin
         fresh_st.col = col_inc;
         if (is_space(ch)) begin
         end else if (is_digit(ch)) begin
            fresh_st.scan      = SCAN_INT;
            fresh_st.tok_start = col_inc;
            fresh_st.tok_len   = LEN_BITS'(1);
         end else if (delim.hit) begin
            fr.kind   = KIND_DELIM;
            fr.detail = delim.code;
            fr_v      = 1'b1;
         end else if (ch == CH_PCT) begin
            fr.kind   = KIND_OP;
            fr.detail = OP_MOD;
            fr_v      = 1'b1;
         end else if (is_op_start(ch)) begin
            fresh_st.scan       = SCAN_OP;
            fresh_st.pending_op = ch;
            fresh_st.tok_start  = col_inc;
            fresh_st.tok_len    = LEN_BITS'(1);
         end else if (is_alpha(ch)) begin
            fresh_st.scan      = SCAN_IDENT;
            fresh_st.kw_live   = kw_first;
            fresh_st.tok_start = col_inc;
            fresh_st.tok_len   = LEN_BITS'(1);
         end else begin
            fr_v = 1'b1;
         end
      end
   end

   // pick the token list and next state
   always_comb begin
      raw[0] = fl0;
      raw[1] = fl1;
      raw[2] = fr;
      if (end_of_text) begin
         nxt       = STATE_RESET;
         res_count = fl_n;
      end else if (!done) begin
         nxt       = fresh_st;
         raw[0]    = (fl_n >= 2'd1) ? fl0 : fr;
         raw[1]    = (fl_n >= 2'd2) ? fl1 : fr;
         res_count = 2'(fl_n + {1'b0, fr_v});
      end else begin
         nxt       = step_st;
         raw[0]    = pr;
         res_count = {1'b0, pr_v};
      end
      for (int i = 0; i < MAX_RES; i++) begin
         res[i]      = raw[i];
         res[i].last = (2'(i + 1) == res_count);
      end
   end

endmodule

`default_nettype wire

[rtl/stt_result_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stt_result_fifo: token queue
// Takes a group of up to three tokens in a single push and hands them out one
// beat at a time in order.
// ----------------------------------------------------------------------------
module stt_result_fifo
   import stt_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  push_count,
   input  token_type [MAX_RES-1:0]     push_data,
   input  logic                        pop,
   output token_type                   head,
   output logic [CNT_BITS-1:0]         count
);

   token_type           mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + CNT_BITS'(push_count) - CNT_BITS'(pop);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push_count) begin
            mem_ff[wr_ptr_ff + PTR_BITS'(i)] <= push_data[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/source_text_tokenizer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit: streaming lexical tokenizer
// Groups source bytes into number, delimiter, operator, keyword, identifier
// and unknown tokens with line, column and length.
// ----------------------------------------------------------------------------
// One source byte is taken per req beat and scanned in the same cycle; the
// tokens it completes go into a four-entry queue and leave on rsp one beat
// per cycle while rsp_stall is low, the final token of each byte marked by
// rsp_last. A byte is taken whenever the queue holds at most one token, so a
// stream in which every byte completes at most one token runs at one byte per
// cycle with rsp draining; a byte that completes two or three tokens (a
// flushed token followed by a delimiter, a dangling dot) holds req_stall high
// until the queue drains. A beat with req_end_of_text flushes the held token
// and returns the scan state, line and column to their reset values. No
// clearing pass after reset.
module source_text_tokenizer_unit
   import stt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_detail,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_length,
   output logic        rsp_last
);

   state_type               state_ff;
   state_type               state_in;
   token_type [MAX_RES-1:0] step_res;
   logic [1:0]              step_count;
   logic [1:0]              push_count;
   logic                    accept;
   logic                    pop;
   token_type               head;
   logic [CNT_BITS-1:0]     queue_count;

   stt_step u_step (
      .cur         (state_ff),
      .ch          (req_ch),
      .end_of_text (req_end_of_text),
      .nxt         (state_in),
      .res         (step_res),
      .res_count   (step_count)
   );

   stt_result_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (step_res),
      .pop        (pop),
      .head       (head),
      .count      (queue_count)
   );

   // hold input while the queue may lack room for a full group
   assign req_stall  = (queue_count > CNT_BITS'(1));
   assign accept     = req_valid && !req_stall;
   assign push_count = accept ? step_count : 2'd0;
   assign rsp_valid  = (queue_count != '0);
   assign pop        = rsp_valid && !rsp_stall;

   assign rsp_kind        = head.kind;
   assign rsp_detail      = head.detail;
   assign rsp_line_number = head.line;
   assign rsp_column      = head.column;
   assign rsp_length      = head.length;
   assign rsp_last        = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= CNT_BITS'(FIFO_DEPTH))
      else $error("token queue overfilled");

   a_group_tail: assert property (@(posedge clock) disable iff (reset)
      (queue_count == CNT_BITS'(1)) |-> rsp_last)
      else $error("queue tail token not marked last");

   a_op_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff.scan == SCAN_OP) |-> (state_ff.pending_op != 8'h00))
      else $error("operator state without pending byte");

   a_eot_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_text) |=>
         ((state_ff.scan == SCAN_IDLE) && (state_ff.line == LINE_BITS'(1)) &&
          (state_ff.col == '0)))
      else $error("end of text did not restart the scan");

endmodule

`default_nettype wire

[tb/sv/source_text_tokenizer_unit_tb.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_tb: self-checking bench of the source tokenizer
// Feeds source bytes as req beats, tracks the scan state in a local lexer,
// and compares every rsp beat field by field with the tokens that the local
// lexer has queued, or the table's for typed rows. A short directed table
// comes first, then random token streams under random idling and one long
// rsp hold-off, then a short stall-free tail closed by an end-of-text beat.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit_tb
   import stt_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_detail;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column;
   logic [15:0] rsp_length;
   logic        rsp_last;

   source_text_tokenizer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_detail      (rsp_detail),
      .rsp_line_number (rsp_line_number),
      .rsp_column      (rsp_column),
      .rsp_length      (rsp_length),
      .rsp_last        (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       typed;
      token_type  want;
   } dir_row_type;

   localparam token_type NO_TOK = '0;

   localparam dir_row_type DIRECTED [0:24] = '{
      '{"(",   1'b0, 1'b1, '{KIND_DELIM, DL_LPAREN, 16'd1, 16'd1, 16'd1, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{KIND_UNKNOWN, 8'hFF, 16'd1, 16'd2, 16'd1, 1'b1}},
      '{8'h00, 1'b0, 1'b1, '{KIND_UNKNOWN, 8'h00, 16'd1, 16'd3, 16'd1, 1'b1}},
      '{"%",   1'b0, 1'b1, '{KIND_OP, OP_MOD, 16'd1, 16'd4, 16'd1, 1'b1}},
      '{8'h09, 1'b0, 1'b0, NO_TOK},
      '{"1",   1'b0, 1'b0, NO_TOK},
      '{".",   1'b0, 1'b0, NO_TOK},
      '{"5",   1'b0, 1'b0, NO_TOK},
      '{"*",   1'b0, 1'b0, NO_TOK},
      '{"*",   1'b0, 1'b0, NO_TOK},
      '{"=",   1'b0, 1'b0, NO_TOK},
      '{CH_LF, 1'b0, 1'b0, NO_TOK},
      '{"7",   1'b0, 1'b0, NO_TOK},
      '{".",   1'b0, 1'b0, NO_TOK},
      '{")",   1'b0, 1'b0, NO_TOK},
      '{"!",   1'b0, 1'b0, NO_TOK},
      '{".",   1'b0, 1'b0, NO_TOK},
      '{"i",   1'b0, 1'b0, NO_TOK},
      '{"f",   1'b0, 1'b0, NO_TOK},
      '{"/",   1'b0, 1'b0, NO_TOK},
      '{"/",   1'b0, 1'b0, NO_TOK},
      '{"=",   1'b0, 1'b0, NO_TOK},
      '{8'h00, 1'b1, 1'b0, NO_TOK},
      '{8'h22, 1'b0, 1'b1, '{KIND_DELIM, DL_DQUOTE, 16'd1, 16'd1, 16'd1, 1'b1}},
      '{"Z",   1'b1, 1'b0, NO_TOK}
   };

   string OP_FORMS [18] = '{"==", "!=", "<=", ">=", "**", "//", "+=", "-=", "*=", "/=",
                            "+", "-", "*", "/", "%", "=", "<", ">"};
   string KW_WORDS [7] = '{"if", "elif", "else", "for", "while", "def", "return"};
   string DELIMS = "{}()[]:\"'";
   string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

   // local lexer state
   scan_type    lx_scan;
   logic [7:0]  lx_pend;
   logic [6:0]  lx_live;
   logic [15:0] lx_line;
   logic [15:0] lx_col;
   logic [15:0] lx_start;
   logic [15:0] lx_len;

   token_type   step_toks[$];
   token_type   tokens_due[$];
   logic [8:0]  text_q[$];

   bit  quiet = 1'b0;
   bit  calm = 1'b0;
   bit  squeeze = 1'b0;
   int  bytes_sent = 0;
   int  tokens_checked = 0;
   int  mismatch_count = 0;
   int  errors = 0;

   function automatic bit num_ch(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit word_ch(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic bit blank_ch(input logic [7:0] c);
      return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
   endfunction

   function automatic int delim_pos(input logic [7:0] c);
      int i;
      for (i = 0; i < 9; i++)
         if (DELIMS[i] == c) return i;
      return -1;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [7:0] lone_op_code(input logic [7:0] p);
      case (p)
         CH_PLUS:  return OP_ADD;
         CH_MINUS: return OP_SUB;
         CH_STAR:  return OP_MUL;
         CH_SLASH: return OP_DIV;
         CH_EQ:    return OP_ASSIGN;
         CH_LT:    return OP_LT;
         default:  return OP_GT;
      endcase
   endfunction

   function automatic int pair_code(input logic [7:0] p, input logic [7:0] c);
      if (c == CH_EQ) begin
         case (p)
            CH_EQ:    return OP_EQ_EQ;
            CH_BANG:  return OP_NE;
            CH_LT:    return OP_LE;
            CH_GT:    return OP_GE;
            CH_PLUS:  return OP_ADD_EQ;
            CH_MINUS: return OP_SUB_EQ;
            CH_STAR:  return OP_MUL_EQ;
            CH_SLASH: return OP_DIV_EQ;
            default:  return -1;
         endcase
      end
      if ((c == CH_STAR) && (p == CH_STAR)) return OP_POW;
      if ((c == CH_SLASH) && (p == CH_SLASH)) return OP_FLOORDIV;
      return -1;
   endfunction

   function automatic void lex_clear();
      lx_scan  = SCAN_IDLE;
      lx_pend  = 8'h00;
      lx_live  = '0;
      lx_line  = 16'd1;
      lx_col   = '0;
      lx_start = '0;
      lx_len   = '0;
   endfunction

   function automatic void emit_tok(input kind_type k, input logic [7:0] d,
                                    input logic [15:0] col, input logic [15:0] len);
      token_type t;
      t.kind   = k;
      t.detail = d;
      t.line   = lx_line;
      t.column = col;
      t.length = len;
      t.last   = 1'b0;
      step_toks.push_back(t);
   endfunction

   // emit whatever tokens the scan state holds, then return to idle
   function automatic void flush_held();
      int  k;
      bit  found;
      found = 1'b0;
      case (lx_scan)
         SCAN_INT:  emit_tok(KIND_NUMBER, DETAIL_NONE, lx_start, lx_len);
         SCAN_DOT: begin
            emit_tok(KIND_NUMBER, DETAIL_NONE, lx_start, lx_len);
            emit_tok(KIND_UNKNOWN, CH_DOT, lx_col, 16'd1);
         end
         SCAN_FRAC: emit_tok(KIND_NUMBER, DETAIL_FRAC, lx_start, lx_len);
         SCAN_IDENT: begin
            for (k = 0; k < NUM_KW; k++) begin
               if (!found && lx_live[k] && (lx_len == 16'(KW_LEN[k]))) begin
                  emit_tok(KIND_KEYWORD, 8'(k), lx_start, lx_len);
                  found = 1'b1;
               end
            end
            if (!found) emit_tok(KIND_IDENT, DETAIL_NONE, lx_start, lx_len);
         end
         SCAN_OP: begin
            if (lx_pend == CH_BANG) emit_tok(KIND_UNKNOWN, CH_BANG, lx_start, 16'd1);
            else emit_tok(KIND_OP, lone_op_code(lx_pend), lx_start, 16'd1);
         end
         default: ;
      endcase
      lx_scan = SCAN_IDLE;
      lx_pend = 8'h00;
      lx_live = '0;
      lx_len  = '0;
   endfunction

   function automatic void start_fresh(input logic [7:0] c);
      logic [15:0] here;
      int          d;
      int          k;
      here = sat_inc(lx_col);
      d = delim_pos(c);
      if (c == CH_LF) begin
         lx_line = sat_inc(lx_line);
         lx_col  = '0;
      end else if (blank_ch(c)) begin
         lx_col = sat_inc(lx_col);
      end else if (num_ch(c)) begin
         lx_scan  = SCAN_INT;
         lx_start = here;
         lx_len   = 16'd1;
         lx_col   = sat_inc(lx_col);
      end else if (d >= 0) begin
         emit_tok(KIND_DELIM, 8'(d), here, 16'd1);
         lx_col = sat_inc(lx_col);
      end else if (c == CH_PCT) begin
         emit_tok(KIND_OP, OP_MOD, here, 16'd1);
         lx_col = sat_inc(lx_col);
      end else if ((c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
                   (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) ||
                   (c == CH_MINUS)) begin
         lx_scan  = SCAN_OP;
         lx_pend  = c;
         lx_start = here;
         lx_len   = 16'd1;
         lx_col   = sat_inc(lx_col);
      end else if (word_ch(c)) begin
         lx_live = '0;
         for (k = 0; k < NUM_KW; k++)
            if (KW_TEXT[k][0] == c) lx_live[k] = 1'b1;
         lx_scan  = SCAN_IDENT;
         lx_start = here;
         lx_len   = 16'd1;
         lx_col   = sat_inc(lx_col);
      end else begin
         emit_tok(KIND_UNKNOWN, c, here, 16'd1);
         lx_col = sat_inc(lx_col);
      end
   endfunction

   // advance the local lexer by one byte; the tokens it completes land in step_toks
   function automatic void lex_byte(input logic [7:0] c, input logic eot);
      bit        taken;
      int        p;
      int        k;
      token_type t;
      step_toks.delete();
      taken = 1'b0;
      if (eot) begin
         flush_held();
         lex_clear();
      end else begin
         case (lx_scan)
            SCAN_INT: begin
               if (num_ch(c)) begin
                  lx_len = sat_inc(lx_len);
                  lx_col = sat_inc(lx_col);
                  taken  = 1'b1;
               end else if (c == CH_DOT) begin
                  lx_scan = SCAN_DOT;
                  lx_col  = sat_inc(lx_col);
                  taken   = 1'b1;
               end
            end
            SCAN_DOT: begin
               if (num_ch(c)) begin
                  lx_len  = sat_inc(sat_inc(lx_len));
                  lx_scan = SCAN_FRAC;
                  lx_col  = sat_inc(lx_col);
                  taken   = 1'b1;
               end
            end
            SCAN_FRAC: begin
               if (num_ch(c)) begin
                  lx_len = sat_inc(lx_len);
                  lx_col = sat_inc(lx_col);
                  taken  = 1'b1;
               end
            end
            SCAN_IDENT: begin
               if (word_ch(c) || num_ch(c)) begin
                  // drop keywords whose next letter no longer matches
                  for (k = 0; k < NUM_KW; k++)
                     if (lx_live[k] && !((lx_len < 16'(KW_LEN[k])) &&
                                         (KW_TEXT[k][lx_len] == c)))
                        lx_live[k] = 1'b0;
                  lx_len = sat_inc(lx_len);
                  lx_col = sat_inc(lx_col);
                  taken  = 1'b1;
               end
            end
            SCAN_OP: begin
               p = pair_code(lx_pend, c);
               if (p >= 0) begin
                  emit_tok(KIND_OP, 8'(p), lx_start, 16'd2);
                  lx_scan = SCAN_IDLE;
                  lx_pend = 8'h00;
                  lx_len  = '0;
                  lx_col  = sat_inc(lx_col);
                  taken   = 1'b1;
               end
            end
            default: ;
         endcase
         if (!taken) begin
            flush_held();
            start_fresh(c);
         end
      end
      if (step_toks.size() > 0) begin
         t = step_toks.pop_back();
         t.last = 1'b1;
         step_toks.push_back(t);
      end
   endfunction

   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) text_q.push_back({1'b0, s[i]});
   endtask

   task automatic put_digits(input int n);
      int i;
      for (i = 0; i < n; i++) text_q.push_back({1'b0, 8'("0" + $urandom_range(0, 9))});
   endtask

   // queue one well-formed token, some noise or an end-of-text beat, and usually a separator
   task automatic compose_chunk();
      int    pick;
      int    k;
      int    i;
      string w;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         put_digits($urandom_range(1, 4));
         if ($urandom_range(0, 2) == 0) begin
            put_text(".");
            put_digits($urandom_range(1, 3));
         end
      end else if (pick < 45) begin
         k = $urandom_range(0, NUM_KW - 1);
         w = KW_WORDS[k];
         case ($urandom_range(0, 4))
            0, 1: put_text(w);
            2:    put_text(w.substr(0, $urandom_range(0, w.len() - 2)));
            3: begin
               put_text(w);
               text_q.push_back({1'b0, ALNUM[$urandom_range(0, 62)]});
            end
            default: begin
               text_q.push_back({1'b0, ALNUM[$urandom_range(0, 52)]});
               for (i = $urandom_range(0, 5); i > 0; i--)
                  text_q.push_back({1'b0, ALNUM[$urandom_range(0, 62)]});
            end
         endcase
      end else if (pick < 70) begin
         put_text(OP_FORMS[$urandom_range(0, 17)]);
      end else if (pick < 82) begin
         text_q.push_back({1'b0, DELIMS[$urandom_range(0, 8)]});
      end else if (pick < 97) begin
         case ($urandom_range(0, 5))
            0: text_q.push_back({1'b0, 8'($urandom)});
            1: put_text("5.");
            2: put_text("!");
            3: put_text(".");
            4: put_text($urandom_range(0, 1) ? "//=" : "**=");
            default: text_q.push_back({1'b0, 8'($urandom_range(128, 255))});
         endcase
      end else begin
         text_q.push_back({1'b1, 8'($urandom)});
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: put_text(" ");
         5: text_q.push_back({1'b0, 8'h09});
         6: text_q.push_back({1'b0, CH_LF});
         7: text_q.push_back({1'b0, 8'h0D});
         default: ;
      endcase
   endtask

   // offer one byte, hold it until the beat is taken, then queue its tokens
   task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                            input token_type want);
      int i;
      if (!quiet && !calm && ($urandom_range(0, 4) == 0)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      lex_byte(c, eot);
      if (typed) tokens_due.push_back(want);
      else for (i = 0; i < step_toks.size(); i++) tokens_due.push_back(step_toks[i]);
   endtask

   initial begin
      int         i;
      int         random_sent;
      int         wait_cycles;
      logic [8:0] w;
      lex_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++)
         send_byte(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].want);

      random_sent = 0;
      while (random_sent < 130) begin
         compose_chunk();
         calm = ($urandom_range(0, 3) == 0);
         while (text_q.size() > 0) begin
            w = text_q.pop_front();
            send_byte(w[7:0], w[8], 1'b0, NO_TOK);
            random_sent++;
            if (random_sent == 90) squeeze = 1'b1;
         end
      end

      // closing stretch with no idling on either side
      quiet = 1'b1;
      while (random_sent < 150) begin
         compose_chunk();
         while (text_q.size() > 0) begin
            w = text_q.pop_front();
            send_byte(w[7:0], w[8], 1'b0, NO_TOK);
            random_sent++;
         end
      end
      send_byte(8'h00, 1'b1, 1'b0, NO_TOK);
      req_valid <= 1'b0;

      wait_cycles = 0;
      while ((tokens_due.size() > 0) && (wait_cycles < 20000)) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (16) @(posedge clock);
      errors += tokens_due.size();

      $display("run: %0d source bytes sent, %0d tokens checked, %0d mismatches",
               bytes_sent, tokens_checked, mismatch_count);
      $display("run: directed corner bytes, random token streams with back-pressure, %s",
               "a long rsp hold-off and a stall-free close");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // rsp side: random stall bursts, one long hold-off on request
   initial begin
      int n;
      wait (!reset);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_stall <= 1'b1;
            n = 0;
            while (n < 300) begin
               @(posedge clock);
               n++;
            end
         end else if (!quiet && ($urandom_range(0, 2) == 0)) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, quiet ? 1 : 25)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_checked++;
         if (tokens_due.size() == 0) begin
            mismatch_count++;
            errors++;
            if (mismatch_count <= 10)
               $display("extra token: kind %0d detail %0h line %0d col %0d len %0d last %0b",
                        rsp_kind, rsp_detail, rsp_line_number, rsp_column, rsp_length,
                        rsp_last);
         end else begin
            want = tokens_due.pop_front();
            if ((rsp_kind !== want.kind) || (rsp_detail !== want.detail) ||
                (rsp_line_number !== want.line) || (rsp_column !== want.column) ||
                (rsp_length !== want.length) || (rsp_last !== want.last)) begin
               mismatch_count++;
               errors++;
               if (mismatch_count <= 10) begin
                  $display("mismatch want: kind %0d detail %0h line %0d col %0d len %0d %0b",
                           want.kind, want.detail, want.line, want.column, want.length,
                           want.last);
                  $display("         got:  kind %0d detail %0h line %0d col %0d len %0d %0b",
                           rsp_kind, rsp_detail, rsp_line_number, rsp_column, rsp_length,
                           rsp_last);
               end
            end
         end
      end
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
